/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, masked while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/vcdg_pkg.sv */
// ----------------------------------------------------------------------------
// vcdg_pkg
// Shared types and constants of the voxel gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package vcdg_pkg;

    localparam int CW     = 5;   // coordinate width
    localparam int VW     = 8;   // voxel width
    localparam int GW     = 9;   // gradient width
    localparam int SW     = 6;   // size register width
    localparam int LW     = 9;   // width for limit compares
    localparam int CFG_AW = 2;   // config index width

    typedef logic [CFG_AW-1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_X_SIZE = 2'd0;
    localparam t_cfg_addr CFG_Y_SIZE = 2'd1;
    localparam t_cfg_addr CFG_Z_SIZE = 2'd2;

    localparam logic [SW-1:0] SIZE_RESET = 6'd32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_GRAD  = 1'b1;

    // neighbor read order
    typedef logic [2:0] t_nb_idx;
    localparam t_nb_idx NB_XB = 3'd0;
    localparam t_nb_idx NB_XF = 3'd1;
    localparam t_nb_idx NB_YB = 3'd2;
    localparam t_nb_idx NB_YF = 3'd3;
    localparam t_nb_idx NB_ZB = 3'd4;
    localparam t_nb_idx NB_ZF = 3'd5;

    typedef struct packed {
        logic    load;
        logic    wr_en;
        logic    rd_en;
        t_nb_idx rd_idx;
        logic    cap_en;
        t_nb_idx cap_idx;
        logic    fin;
        logic    oor;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_vol;
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/vcdg_ram.sv */
// ----------------------------------------------------------------------------
// vcdg_ram
// Generic single-port RAM, one access per cycle (a write also reads the old word), registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vcdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/vcdg_ctrl.sv */
// ----------------------------------------------------------------------------
// vcdg_ctrl
// Request sequencer: accepts requests, steps the six neighbor reads and
// issues the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module vcdg_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_opcode,
    input  wire vcdg_pkg::t_dp_status i_status,
    output vcdg_pkg::t_ctrl_cmd       o_cmd,
    output logic                      o_busy,
    output logic                      o_valid
);

    import vcdg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    t_nb_idx    r_idx, n_idx;
    logic       r_valid, n_valid;
    logic       accept;
    t_ctrl_cmd  cmd;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        cmd         = '0;
        cmd.load    = accept;
        cmd.wr_en   = accept && (i_opcode == OP_WRITE) && i_status.in_vol;
        cmd.oor     = accept && (i_opcode == OP_GRAD) && !i_status.in_vol;
        cmd.rd_en   = (r_state == ST_READ);
        cmd.rd_idx  = r_idx;
        cmd.cap_en  = (r_state == ST_READ) && (r_idx != NB_XB);
        cmd.cap_idx = r_idx - 3'd1;
        cmd.fin     = (r_state == ST_FIN);
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = NB_XB;
                if (accept && (i_opcode == OP_GRAD) && i_status.in_vol) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_idx = r_idx + 3'd1;
                if (r_idx == NB_ZF) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_valid = cmd.fin || cmd.oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= NB_XB;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_cmd   = cmd;
    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* hw/rtl/vcdg_dp.sv */
// ----------------------------------------------------------------------------
// vcdg_dp
// Datapath: size registers, range checks, voxel RAM addressing, neighbor
// capture and gradient output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vcdg_dp #(
    parameter int AXIS_SIZE = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire vcdg_pkg::t_ctrl_cmd      i_cmd,
    output vcdg_pkg::t_dp_status          o_status,
    input  wire logic                     i_cfg_we,
    input  wire vcdg_pkg::t_cfg_addr      i_cfg_addr,
    input  wire logic [vcdg_pkg::SW-1:0]  i_cfg_wdata,
    input  wire logic [vcdg_pkg::CW-1:0]  i_coord_x,
    input  wire logic [vcdg_pkg::CW-1:0]  i_coord_y,
    input  wire logic [vcdg_pkg::CW-1:0]  i_coord_z,
    input  wire logic [vcdg_pkg::VW-1:0]  i_voxel_value,
    output logic signed [vcdg_pkg::GW-1:0] o_grad_x,
    output logic signed [vcdg_pkg::GW-1:0] o_grad_y,
    output logic signed [vcdg_pkg::GW-1:0] o_grad_z,
    output logic                          o_out_of_range
);

    import vcdg_pkg::*;

    localparam int AW    = $clog2(AXIS_SIZE);
    localparam int MAW   = 3 * AW;
    localparam int DEPTH = 1 << MAW;
    localparam logic [LW-1:0] AXIS_LIM = LW'(AXIS_SIZE);

    logic [SW-1:0] r_x_size, r_y_size, r_z_size;

    logic [LW-1:0]    x9, y9, z9;
    logic [AW+CW-1:0] xe, ye, ze;
    logic [5:0]       ok;
    logic [5:0]       r_ok;
    logic [AW-1:0]    r_cx, r_cy, r_cz;
    logic [MAW-1:0]   in_addr, nb_addr, ram_addr;
    logic [VW-1:0]    ram_rdata, zf;
    logic [VW-1:0]    r_xb, r_xf, r_yb, r_yf, r_zb;
    logic signed [GW-1:0] r_grad_x, r_grad_y, r_grad_z;
    logic             r_oor;

    function automatic logic below(input logic [LW-1:0] v, input logic [SW-1:0] sz);
        return (v < LW'(sz)) && (v < AXIS_LIM);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= SIZE_RESET;
            r_y_size <= SIZE_RESET;
            r_z_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_X_SIZE: r_x_size <= i_cfg_wdata;
                CFG_Y_SIZE: r_y_size <= i_cfg_wdata;
                CFG_Z_SIZE: r_z_size <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign x9 = LW'(i_coord_x);
    assign y9 = LW'(i_coord_y);
    assign z9 = LW'(i_coord_z);

    assign o_status.in_vol = below(x9, r_x_size) && below(y9, r_y_size)
                             && below(z9, r_z_size);

    always_comb begin
        ok        = '0;
        ok[NB_XB] = (i_coord_x != '0);
        ok[NB_XF] = below(x9 + LW'(1), r_x_size);
        ok[NB_YB] = (i_coord_y != '0);
        ok[NB_YF] = below(y9 + LW'(1), r_y_size);
        ok[NB_ZB] = (i_coord_z != '0);
        ok[NB_ZF] = below(z9 + LW'(1), r_z_size);
    end

    assign xe = {{AW{1'b0}}, i_coord_x};
    assign ye = {{AW{1'b0}}, i_coord_y};
    assign ze = {{AW{1'b0}}, i_coord_z};
    assign in_addr = {ze[AW-1:0], ye[AW-1:0], xe[AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ok <= ok;
            r_cx <= xe[AW-1:0];
            r_cy <= ye[AW-1:0];
            r_cz <= ze[AW-1:0];
        end
    end

    always_comb begin
        unique case (i_cmd.rd_idx)
            NB_XB:   nb_addr = {r_cz, r_cy, r_cx - AW'(1)};
            NB_XF:   nb_addr = {r_cz, r_cy, r_cx + AW'(1)};
            NB_YB:   nb_addr = {r_cz, r_cy - AW'(1), r_cx};
            NB_YF:   nb_addr = {r_cz, r_cy + AW'(1), r_cx};
            NB_ZB:   nb_addr = {r_cz - AW'(1), r_cy, r_cx};
            default: nb_addr = {r_cz + AW'(1), r_cy, r_cx};
        endcase
    end

    assign ram_addr = i_cmd.rd_en ? nb_addr : in_addr;

    vcdg_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_addr  (ram_addr),
        .i_wdata (i_voxel_value),
        .o_rdata (ram_rdata)
    );

    // neighbors outside the volume read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            unique case (i_cmd.cap_idx)
                NB_XB: r_xb <= r_ok[NB_XB] ? ram_rdata : '0;
                NB_XF: r_xf <= r_ok[NB_XF] ? ram_rdata : '0;
                NB_YB: r_yb <= r_ok[NB_YB] ? ram_rdata : '0;
                NB_YF: r_yf <= r_ok[NB_YF] ? ram_rdata : '0;
                NB_ZB: r_zb <= r_ok[NB_ZB] ? ram_rdata : '0;
                default: begin
                end
            endcase
        end
    end

    assign zf = r_ok[NB_ZF] ? ram_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.oor) begin
            r_grad_x <= '0;
            r_grad_y <= '0;
            r_grad_z <= '0;
            r_oor    <= 1'b1;
        end else if (i_cmd.fin) begin
            r_grad_x <= $signed({1'b0, r_xf} - {1'b0, r_xb});
            r_grad_y <= $signed({1'b0, r_yf} - {1'b0, r_yb});
            r_grad_z <= $signed({1'b0, zf} - {1'b0, r_zb});
            r_oor    <= 1'b0;
        end
    end

    assign o_grad_x       = r_grad_x;
    assign o_grad_y       = r_grad_y;
    assign o_grad_z       = r_grad_z;
    assign o_out_of_range = r_oor;

endmodule

`default_nettype wire

/* hw/rtl/volume_central_difference_gradient.sv */
// Gradient request: after accept the sequencer steps the six neighbor reads, then a finish state, and
//   the result strobe is registered from it; the next request is taken in the cycle the strobe shows.
// The six neighbor reads go one per cycle through the single-port voxel RAM.
// Write and out-of-range requests: taken without leaving idle, result (if any) on the next cycle.
// Reset (synchronous): sizes to 32, sequencer idle; voxel RAM is not cleared.
// ----------------------------------------------------------------------------
// volume_central_difference_gradient
// Voxel volume store with central-difference gradient lookup.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module volume_central_difference_gradient #(
    parameter int AXIS_SIZE = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire vcdg_pkg::t_cfg_addr          i_cfg_addr,
    input  wire logic [vcdg_pkg::SW-1:0]      i_cfg_wdata,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_opcode,
    input  wire logic [vcdg_pkg::CW-1:0]      i_coord_x,
    input  wire logic [vcdg_pkg::CW-1:0]      i_coord_y,
    input  wire logic [vcdg_pkg::CW-1:0]      i_coord_z,
    input  wire logic [vcdg_pkg::VW-1:0]      i_voxel_value,
    output logic                              o_valid,
    output logic signed [vcdg_pkg::GW-1:0]    o_grad_x,
    output logic signed [vcdg_pkg::GW-1:0]    o_grad_y,
    output logic signed [vcdg_pkg::GW-1:0]    o_grad_z,
    output logic                              o_out_of_range
);

    import vcdg_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    vcdg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    vcdg_dp #(
        .AXIS_SIZE (AXIS_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_voxel_value  (i_voxel_value),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_grad_z       (o_grad_z),
        .o_out_of_range (o_out_of_range)
    );

    `ASSERT_CLK(a_valid_idle, i_clk, i_rst_n, o_valid |-> !o_busy, "result strobe while busy")
    `ASSERT_CLK(a_oor_zero, i_clk, i_rst_n, (o_valid && o_out_of_range) |-> ((o_grad_x == '0) && (o_grad_y == '0) && (o_grad_z == '0)), "nonzero gradient on out-of-range result")
    `ASSERT_CLK(a_grad_progress, i_clk, i_rst_n, (i_start && !o_busy && (i_opcode == OP_GRAD)) |=> (o_busy || o_valid), "gradient request dropped")
    `ASSERT_CLK(a_write_silent, i_clk, i_rst_n, (i_start && !o_busy && (i_opcode == OP_WRITE)) |=> (!o_valid && !o_busy), "write request produced a result")

endmodule

`default_nettype wire
